// ===== src/csvt_pkg.sv =====
// Package: shared types and constants of the CSV field tokenizer.
`timescale 1ns / 1ps

package csvt_pkg;

    localparam int unsigned CHAR_W = 16;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KIND_W = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned MAX_RES = 3;

    localparam logic [CHAR_W-1:0] CR_CODE = 16'd13;

    localparam logic [KIND_W-1:0] KIND_DATA       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FIELD_END  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FIELD_REC  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REC_END    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_STREAM_END = 3'd4;

    localparam logic [1:0] ENC_BYTE     = 2'd0;
    localparam logic [1:0] ENC_UTF16_LE = 2'd1;
    localparam logic [1:0] ENC_UTF16_BE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FIELD_SEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_DELIM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECORD_SEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALLOW_NL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENCODING   = 3'd4;

    localparam logic [CHAR_W-1:0] FIELD_SEP_RST  = 16'd44;
    localparam logic [CHAR_W-1:0] TEXT_DELIM_RST = 16'd34;
    localparam logic [CHAR_W-1:0] RECORD_SEP_RST = 16'd10;

    typedef struct packed {
        logic [CHAR_W-1:0] field_separator;
        logic [CHAR_W-1:0] text_delimiter;
        logic [CHAR_W-1:0] record_separator;
        logic              allow_embedded_newlines;
        logic [1:0]        char_encoding;
    } t_cfg;

    typedef struct packed {
        logic              in_quotes;
        logic              quote_pending;
        logic              field_has_data;
        logic              byte_phase;
        logic [BYTE_W-1:0] first_byte;
    } t_state;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic [KIND_W-1:0] kind;
        logic              last_result;
    } t_result;

    localparam t_state STATE_RST = '{
        in_quotes: 1'b0, quote_pending: 1'b0, field_has_data: 1'b0,
        byte_phase: 1'b0, first_byte: 8'd0
    };

endpackage

// ===== src/csvt_in_if.sv =====
// Interface: input byte channel of the CSV field tokenizer.
`timescale 1ns / 1ps

interface csvt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink (input valid, input in_byte, input end_of_stream, output ready);
endinterface

// ===== src/csvt_out_if.sv =====
// Interface: result channel of the CSV field tokenizer.
`timescale 1ns / 1ps

interface csvt_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] char_code;
    logic [2:0]  kind;
    logic        last_result;

    modport source (output valid, output char_code, output kind, output last_result,
                    input ready);
    modport sink (input valid, input char_code, input kind, input last_result,
                  output ready);
endinterface

// ===== src/csv_field_tokenizer.sv =====
// Top level: CSV field tokenizer with configuration registers and tokenizer state.
// The first result of an item is offered in the cycle after the item is accepted.
// Throughput: one byte per cycle while each item gives at most one result and the output is
// ready; an item with k results holds the output until all k have left, and the next byte is
// taken in the cycle its last result leaves. A byte that gives no result only updates state.
// Synchronous active-low reset clears tokenizer state, results and registers to defaults.
`timescale 1ns / 1ps

module csv_field_tokenizer
    import csvt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CHAR_W-1:0]    i_cfg_data,
    csvt_in_if.sink              i_in,
    csvt_out_if.source           o_out
);

    t_cfg       r_cfg;
    t_state     r_state;
    t_state     n_state;
    t_result    res [MAX_RES];
    logic [1:0] cnt;
    logic       can_load;
    logic       accept;

    assign i_in.ready = can_load;
    assign accept     = i_in.valid && can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.field_separator         <= FIELD_SEP_RST;
            r_cfg.text_delimiter          <= TEXT_DELIM_RST;
            r_cfg.record_separator        <= RECORD_SEP_RST;
            r_cfg.allow_embedded_newlines <= 1'b0;
            r_cfg.char_encoding           <= ENC_BYTE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FIELD_SEP:  r_cfg.field_separator         <= i_cfg_data;
                REG_TEXT_DELIM: r_cfg.text_delimiter          <= i_cfg_data;
                REG_RECORD_SEP: r_cfg.record_separator        <= i_cfg_data;
                REG_ALLOW_NL:   r_cfg.allow_embedded_newlines <= i_cfg_data[0];
                REG_ENCODING:   r_cfg.char_encoding           <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RST;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    csvt_decode u_decode (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_byte  (i_in.in_byte),
        .i_eos   (i_in.end_of_stream),
        .o_state (n_state),
        .o_res   (res),
        .o_cnt   (cnt)
    );

    csvt_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept && cnt != 2'd0),
        .i_res      (res),
        .i_cnt      (cnt),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

`ifndef ASSERT_OFF
    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.end_of_stream) |=> (r_state == STATE_RST))
        else $error("tokenizer state not cleared after end of stream");
    a_eos_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.end_of_stream) |=> o_out.valid)
        else $error("end of stream gave no result");
    a_byte_mode_no_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_cfg.char_encoding != ENC_UTF16_LE && r_cfg.char_encoding != ENC_UTF16_BE)
        |=> !r_state.byte_phase)
        else $error("byte phase set in single-byte mode");
`endif

endmodule

// ===== src/csvt_decode.sv =====
// Combinational tokenizer step: next state and result list for one input byte.
`timescale 1ns / 1ps

module csvt_decode
    import csvt_pkg::*;
(
    input  t_cfg              i_cfg,
    input  t_state            i_state,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_eos,
    output t_state            o_state,
    output t_result           o_res [MAX_RES],
    output logic [1:0]        o_cnt
);

    t_state            st;
    t_result           res [MAX_RES];
    logic [1:0]        n;
    logic              have_char;
    logic [CHAR_W-1:0] c;

    always_comb begin
        st        = i_state;
        n         = 2'd0;
        have_char = 1'b0;
        c         = '0;
        for (int i = 0; i < MAX_RES; i++) begin
            res[i] = '0;
        end

        if (i_cfg.char_encoding == ENC_UTF16_LE || i_cfg.char_encoding == ENC_UTF16_BE) begin
            if (!st.byte_phase) begin
                st.first_byte = i_byte;
                st.byte_phase = 1'b1;
            end else begin
                if (i_cfg.char_encoding == ENC_UTF16_LE) begin
                    c = {i_byte, st.first_byte};
                end else begin
                    c = {st.first_byte, i_byte};
                end
                st.byte_phase = 1'b0;
                st.first_byte = '0;
                have_char     = 1'b1;
            end
        end else begin
            st.byte_phase = 1'b0;
            st.first_byte = '0;
            c             = {{(CHAR_W-BYTE_W){1'b0}}, i_byte};
            have_char     = 1'b1;
        end

        if (have_char) begin
            if (c == CR_CODE) begin
                if (st.quote_pending) begin
                    st.in_quotes     = ~st.in_quotes;
                    st.quote_pending = 1'b0;
                end
            end else if (c == i_cfg.text_delimiter) begin
                if (st.quote_pending) begin
                    // doubled delimiter: one literal delimiter
                    st.quote_pending  = 1'b0;
                    st.field_has_data = 1'b1;
                    res[n]            = '{char_code: c, kind: KIND_DATA, last_result: 1'b0};
                    n                 = n + 2'd1;
                end else begin
                    st.quote_pending = 1'b1;
                end
            end else begin
                if (st.quote_pending) begin
                    st.in_quotes     = ~st.in_quotes;
                    st.quote_pending = 1'b0;
                end
                if (c == i_cfg.field_separator && !st.in_quotes) begin
                    st.field_has_data = 1'b0;
                    res[n] = '{char_code: '0, kind: KIND_FIELD_END, last_result: 1'b0};
                    n      = n + 2'd1;
                end else if (c == i_cfg.record_separator &&
                             !(i_cfg.allow_embedded_newlines && st.in_quotes)) begin
                    res[n] = '{char_code: '0,
                               kind: st.field_has_data ? KIND_FIELD_REC : KIND_REC_END,
                               last_result: 1'b0};
                    n      = n + 2'd1;
                    st.field_has_data = 1'b0;
                end else begin
                    st.field_has_data = 1'b1;
                    res[n] = '{char_code: c, kind: KIND_DATA, last_result: 1'b0};
                    n      = n + 2'd1;
                end
            end
        end

        if (i_eos) begin
            if (st.field_has_data) begin
                res[n] = '{char_code: '0, kind: KIND_FIELD_END, last_result: 1'b0};
                n      = n + 2'd1;
            end
            res[n] = '{char_code: '0, kind: KIND_STREAM_END, last_result: 1'b0};
            n      = n + 2'd1;
            st     = STATE_RST;
        end

        for (int i = 0; i < MAX_RES; i++) begin
            res[i].last_result = (2'(i + 1) == n);
        end
    end

    assign o_state = st;
    assign o_res   = res;
    assign o_cnt   = n;

endmodule

// ===== src/csvt_outbuf.sv =====
// Result register: holds up to three results of one item and hands them out in order.
`timescale 1ns / 1ps

module csvt_outbuf
    import csvt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_result     i_res [MAX_RES],
    input  logic [1:0]  i_cnt,
    output logic        o_can_load,
    csvt_out_if.source  o_out
);

    t_result    r_slot [MAX_RES];
    logic [1:0] r_left;
    logic       take;

    assign take       = o_out.valid && o_out.ready;
    assign o_can_load = (r_left == 2'd0) || (r_left == 2'd1 && take);

    assign o_out.valid       = (r_left != 2'd0);
    assign o_out.char_code   = r_slot[0].char_code;
    assign o_out.kind        = r_slot[0].kind;
    assign o_out.last_result = r_slot[0].last_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 2'd0;
        end else if (i_load) begin
            r_left <= i_cnt;
        end else if (take) begin
            r_left <= r_left - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_res;
        end else if (take) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

`ifndef ASSERT_OFF
    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.last_result == (r_left == 2'd1)))
        else $error("last_result flag out of step with remaining count");
    a_load_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_can_load)
        else $error("result buffer loaded while results still pending");
    a_drain_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_left > 2'd1 && !i_load) |=> o_out.valid)
        else $error("pending results lost after take");
`endif

endmodule
